// File: sv/rxfw_pkg.sv
// shared types and constants for the receive ring buffer with reply watcher
// no dependencies; imported by rxfw_ring, rxfw_watch and rx_fifo_with_reply_watch
package rxfw_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_START = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        EVT_NONE    = 2'd0,
        EVT_MATCH   = 2'd1,
        EVT_TIMEOUT = 2'd2
    } evt_e;

    localparam int BYTE_W    = 8;
    localparam int KEY_W     = 64;
    localparam int LEN_W     = 4;
    localparam int TMO_W     = 16;
    localparam int LEVEL_W   = 11;
    localparam int CMD_W     = 2;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] EMPTY_READ = 8'hFF;

    typedef struct packed {
        logic               rd_hit;
        logic               empty;
        logic               full;
        logic [LEVEL_W-1:0] level;
    } ring_stat_t;

endpackage

// File: sv/rx_fifo_with_reply_watch.sv
// top level: receive ring buffer with reply watcher, stream in and stream out
// depends on rxfw_pkg, rxfw_ring, rxfw_watch
//
// Input channel s_*: one transfer is one command (s_tuser) with its arguments in
// s_tdata: push a received byte, pop the oldest byte, start a reply watch, or a
// one millisecond tick. Every input transfer yields exactly one output transfer
// on m_* carrying the popped byte (0xFF if none), empty and full flags, the fill
// level and the watch event, all as they stand after that command.
// Throughput is one command per cycle while the receiver does not stall. From
// input transfer to m_tvalid, the byte memory read port and the watcher state
// update first, then the output register is loaded.
// The byte memory and output data are not cleared; positions, watcher state
// and m_tvalid are cleared by aresetn; the block accepts commands right after.
// When the receiver stalls, the output register and the stage behind it hold
// two results; s_tready then drops until m_tready returns, and nothing is lost.
module rx_fifo_with_reply_watch #(
    parameter int FIFO_DEPTH  = 2048,
    parameter int MAX_KEYWORD = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // rx_byte, keyword, keyword_len, timeout_ms, zero pad
    input  logic [rxfw_pkg::S_TDATA_W-1:0]  s_tdata,
    // command
    input  logic [rxfw_pkg::CMD_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_byte, buffer_empty, buffer_full, fill_level, watch_event, zero pad
    output logic [rxfw_pkg::M_TDATA_W-1:0]  m_tdata
);
    import rxfw_pkg::*;

    logic                  op_valid;
    cmd_e                  op_cmd;
    logic [BYTE_W-1:0]     rx_byte;
    logic [KEY_W-1:0]      keyword;
    logic [LEN_W-1:0]      keyword_len;
    logic [TMO_W-1:0]      timeout_ms;
    logic                  push_ok;
    logic [BYTE_W-1:0]     rd_data;
    ring_stat_t            stat;
    evt_e                  watch_event;

    logic                  p1_valid_reg, p1_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;
    logic                  out_load;
    logic [BYTE_W-1:0]     read_byte;

    assign rx_byte     = s_tdata[7:0];
    assign keyword     = s_tdata[71:8];
    assign keyword_len = s_tdata[75:72];
    assign timeout_ms  = s_tdata[91:76];
    assign op_cmd      = cmd_e'(s_tuser);

    assign out_load = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || out_load;
    assign op_valid = s_tvalid && s_tready;

    rxfw_ring #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (op_valid),
        .op_cmd   (op_cmd),
        .op_byte  (rx_byte),
        .push_ok  (push_ok),
        .rd_data  (rd_data),
        .stat     (stat)
    );

    rxfw_watch #(
        .MAX_KEYWORD (MAX_KEYWORD)
    ) u_watch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op_valid    (op_valid),
        .op_cmd      (op_cmd),
        .push_ok     (push_ok),
        .op_byte     (rx_byte),
        .keyword     (keyword),
        .keyword_len (keyword_len),
        .timeout_ms  (timeout_ms),
        .watch_event (watch_event)
    );

    always_comb begin
        read_byte      = stat.rd_hit ? rd_data : EMPTY_READ;
        p1_valid_next  = op_valid || (p1_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && !m_tready);
        out_data_next  = out_data_reg;
        if (out_load) begin
            out_data_next = {1'b0, watch_event, stat.level, stat.full, stat.empty, read_byte};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: sv/rxfw_ring.sv
// ring buffer: byte memory with one write and one registered read port, plus positions
// depends on rxfw_pkg
module rxfw_ring #(
    parameter int FIFO_DEPTH = 2048
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         op_valid,
    input  rxfw_pkg::cmd_e               op_cmd,
    input  logic [rxfw_pkg::BYTE_W-1:0]  op_byte,
    output logic                         push_ok,
    output logic [rxfw_pkg::BYTE_W-1:0]  rd_data,
    output rxfw_pkg::ring_stat_t         stat
);
    import rxfw_pkg::*;

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CALC_W = (PTR_W + 1 > LEVEL_W) ? PTR_W + 1 : LEVEL_W;
    localparam logic [PTR_W-1:0]  LAST_POS = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CALC_W-1:0] DEPTH_EXT = CALC_W'(FIFO_DEPTH);

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    logic [BYTE_W-1:0] byte_store [FIFO_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]  rd_pos_reg, rd_pos_next;
    logic [PTR_W-1:0]  wr_pos_reg, wr_pos_next;
    ring_stat_t        stat_reg, stat_next;
    logic              pop_hit;
    logic [CALC_W-1:0] level_calc;

    always_comb begin
        rd_pos_next = rd_pos_reg;
        wr_pos_next = wr_pos_reg;
        push_ok     = 1'b0;
        pop_hit     = 1'b0;
        if (op_valid) begin
            unique case (op_cmd)
                CMD_PUSH: begin
                    if (rd_pos_reg != advance(wr_pos_reg)) begin
                        push_ok     = 1'b1;
                        wr_pos_next = advance(wr_pos_reg);
                    end
                end
                CMD_POP: begin
                    if (rd_pos_reg != wr_pos_reg) begin
                        pop_hit     = 1'b1;
                        rd_pos_next = advance(rd_pos_reg);
                    end
                end
                CMD_START: begin
                    wr_pos_next = rd_pos_reg;
                end
                CMD_TICK: begin
                end
            endcase
        end

        level_calc = CALC_W'(wr_pos_next) - CALC_W'(rd_pos_next)
                   + ((wr_pos_next < rd_pos_next) ? DEPTH_EXT : '0);

        stat_next        = stat_reg;
        if (op_valid) begin
            stat_next.rd_hit = pop_hit;
            stat_next.empty  = (rd_pos_next == wr_pos_next);
            stat_next.full   = (rd_pos_next == advance(wr_pos_next));
            stat_next.level  = level_calc[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pos_reg <= '0;
            wr_pos_reg <= '0;
            stat_reg   <= '0;
        end else begin
            rd_pos_reg <= rd_pos_next;
            wr_pos_reg <= wr_pos_next;
            stat_reg   <= stat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            byte_store[wr_pos_reg] <= op_byte;
        end
        if (pop_hit) begin
            rd_data_reg <= byte_store[rd_pos_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign stat    = stat_reg;

endmodule

// File: sv/rxfw_watch.sv
// reply watcher: keyword matcher over stored bytes and millisecond timeout counter
// depends on rxfw_pkg
module rxfw_watch #(
    parameter int MAX_KEYWORD = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         op_valid,
    input  rxfw_pkg::cmd_e               op_cmd,
    input  logic                         push_ok,
    input  logic [rxfw_pkg::BYTE_W-1:0]  op_byte,
    input  logic [rxfw_pkg::KEY_W-1:0]   keyword,
    input  logic [rxfw_pkg::LEN_W-1:0]   keyword_len,
    input  logic [rxfw_pkg::TMO_W-1:0]   timeout_ms,
    output rxfw_pkg::evt_e               watch_event
);
    import rxfw_pkg::*;

    localparam int KIDX_W = (MAX_KEYWORD > 1) ? $clog2(MAX_KEYWORD) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_KEYWORD);

    logic [BYTE_W-1:0] key_reg  [MAX_KEYWORD];
    logic [BYTE_W-1:0] key_next [MAX_KEYWORD];
    logic              watching_reg, watching_next;
    logic [LEN_W-1:0]  match_count_reg, match_count_next;
    logic [LEN_W-1:0]  watch_len_reg, watch_len_next;
    logic [TMO_W-1:0]  elapsed_reg, elapsed_next;
    logic [TMO_W-1:0]  limit_reg, limit_next;
    evt_e              event_reg, event_next;

    logic [LEN_W-1:0]  match_idx;
    logic [LEN_W-1:0]  match_inc;
    logic [LEN_W-1:0]  len_sat;
    logic [TMO_W-1:0]  elapsed_inc;
    logic [BYTE_W-1:0] key_cur;

    always_comb begin
        watching_next    = watching_reg;
        match_count_next = match_count_reg;
        watch_len_next   = watch_len_reg;
        elapsed_next     = elapsed_reg;
        limit_next       = limit_reg;
        event_next       = event_reg;
        for (int i = 0; i < MAX_KEYWORD; i++) begin
            key_next[i] = key_reg[i];
        end

        match_idx   = (match_count_reg >= watch_len_reg) ? '0 : match_count_reg;
        match_inc   = match_idx + 1'b1;
        key_cur     = key_reg[match_idx[KIDX_W-1:0]];
        len_sat     = (keyword_len > MAX_LEN) ? MAX_LEN : keyword_len;
        elapsed_inc = elapsed_reg + 1'b1;

        if (op_valid) begin
            event_next = EVT_NONE;
            unique case (op_cmd)
                CMD_PUSH: begin
                    if (push_ok && watching_reg) begin
                        if (op_byte == key_cur) begin
                            if (match_inc >= watch_len_reg) begin
                                watching_next    = 1'b0;
                                match_count_next = '0;
                                event_next       = EVT_MATCH;
                            end else begin
                                match_count_next = match_inc;
                            end
                        end else begin
                            match_count_next = (op_byte == key_reg[0]) ? LEN_W'(1) : '0;
                        end
                    end
                end
                CMD_POP: begin
                end
                CMD_START: begin
                    for (int i = 0; i < MAX_KEYWORD; i++) begin
                        key_next[i] = keyword[i*BYTE_W +: BYTE_W];
                    end
                    watch_len_next   = len_sat;
                    limit_next       = timeout_ms;
                    elapsed_next     = '0;
                    match_count_next = '0;
                    watching_next    = 1'b0;
                    if (len_sat == '0) begin
                        event_next = EVT_MATCH;
                    end else if (timeout_ms == '0) begin
                        event_next = EVT_TIMEOUT;
                    end else begin
                        watching_next = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (watching_reg) begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= limit_reg) begin
                            watching_next    = 1'b0;
                            match_count_next = '0;
                            event_next       = EVT_TIMEOUT;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            watching_reg    <= 1'b0;
            match_count_reg <= '0;
            watch_len_reg   <= '0;
            elapsed_reg     <= '0;
            limit_reg       <= '0;
            event_reg       <= EVT_NONE;
            for (int i = 0; i < MAX_KEYWORD; i++) begin
                key_reg[i] <= '0;
            end
        end else begin
            watching_reg    <= watching_next;
            match_count_reg <= match_count_next;
            watch_len_reg   <= watch_len_next;
            elapsed_reg     <= elapsed_next;
            limit_reg       <= limit_next;
            event_reg       <= event_next;
            for (int i = 0; i < MAX_KEYWORD; i++) begin
                key_reg[i] <= key_next[i];
            end
        end
    end

    assign watch_event = event_reg;

endmodule
